### src/dfp_pkg.sv
// dfp_pkg: shared types and constants of the detection frame parser
// used by dfp_ctrl, dfp_dp and detection_frame_parser
package dfp_pkg;

   localparam int MaxTargets   = 20;
   localparam int VersionBytes = 16;
   localparam int NumChannels  = 4;
   localparam int RecBytes     = 9;
   localparam int BufLen       = 3 + MaxTargets * RecBytes;
   localparam int BufAw        = $clog2(BufLen);
   localparam int ChanAw       = (NumChannels > 1) ? $clog2(NumChannels) : 1;

   localparam logic [7:0] ByteHdr  = 8'hFF;
   localparam logic [7:0] ByteAa   = 8'hAA;
   localparam logic [7:0] ByteBb   = 8'hBB;
   localparam logic [7:0] ByteCc   = 8'hCC;
   localparam logic [7:0] ByteDd   = 8'hDD;
   localparam logic [7:0] OpMd5Req = 8'h00;
   localparam logic [7:0] OpMd5Snd = 8'h01;
   localparam logic [7:0] OpSdk    = 8'h04;
   localparam logic [7:0] OpFail   = 8'h05;
   localparam logic [7:0] OpNone   = 8'h98;
   localparam logic [7:0] OpOk     = 8'h99;
   localparam logic [15:0] CrcPoly = 16'hA001;

   localparam logic [1:0] CsrMinChan = 2'd0;
   localparam logic [1:0] CsrMaxChan = 2'd1;
   localparam logic [1:0] CsrMaxShown = 2'd2;
   localparam logic [1:0] CsrTimeout = 2'd3;

   typedef enum logic [3:0] {
      EV_TARGET, EV_CLEAR, EV_RESEND, EV_RANGE, EV_MD5REQ, EV_MD5SEND,
      EV_SDK, EV_FAIL, EV_NONE, EV_OK, EV_TIMEOUT, EV_CRCERR, EV_OVERFLOW,
      EV_VERBYTE, EV_VERDONE
   } event_type;

   typedef enum logic [3:0] {
      PS_HUNT, PS_TYPE, PS_AA_CHAN, PS_AA_CLASS, PS_AA_COUNT, PS_AA_DATA,
      PS_CRC1, PS_CRC2, PS_BB_CHAN, PS_BB_OP, PS_CC_OP, PS_DD_VER,
      PS_EMIT_RD, PS_EMIT_GATHER, PS_EMIT_OUT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic       buf_wr;        // write rx byte into frame buffer at index
      logic       idx_load3;     // byte index := 3
      logic       idx_clear;     // byte index := 0
      logic       idx_inc;       // byte index += 1
      logic       crc_init;      // crc := add(0, byte)
      logic       crc_add;       // crc := add(crc, byte)
      logic       crc_lo;        // capture received crc low byte
      logic       crc_hi;        // capture received crc high byte
      logic       hdr_store;     // store object class header reg
      logic       chan_store;    // store channel only
      logic       rd_start;      // begin record readout, rec := 0
      logic       rd_step;       // read next buffer byte of record
      logic       rec_next;      // advance to next record
      logic       out_load;      // load output register
      event_type  out_kind;
      logic       out_use_byte;  // version byte from rx
      logic       out_armed;     // reboot_armed from flag
      logic [1:0] out_cnt_sel;   // 0 zero, 1 max, 2 frame count, 3 shown
      logic       out_chan;      // channel field from stored channel
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic data_done;   // last data byte of frame arrives now
      logic crc_good;    // received crc matches (with current high byte)
      logic rd_done;     // last of the 9 bytes of current record arrives now
      logic rec_last;    // current record is the last one shown
      logic shown_zero;  // no records to show
      logic out_busy;    // output register holds an item
   } stat_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] x;
      x = c ^ {8'd0, b};
      for (int i = 0; i < 8; i++)
         x = x[0] ? ((x >> 1) ^ CrcPoly) : (x >> 1);
      return x;
   endfunction

endpackage

### src/dfp_ram.sv
// dfp_ram: generic single-port write, registered-read memory
// no dependencies
module dfp_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

### src/dfp_dp.sv
// dfp_dp: datapath of the frame parser: buffer, crc, header, record gather, output register
// depends on dfp_pkg and dfp_ram
module dfp_dp import dfp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [7:0]  rx_byte,
   input  logic [4:0]  max_shown,
   input  logic        armed,
   input  logic        out_take,
   output logic        out_valid,
   output logic [127:0] out_data,
   output logic        out_last
);
   logic [BufAw-1:0] idx_ff, idx_in;
   logic [15:0] crc_ff, crc_in, crc_rx_ff;
   logic [7:0]  chan_ff;
   logic [1:0]  cls_ff;
   logic [4:0]  cnt_ff, shown_ff;
   logic [4:0]  rec_ff;
   logic [3:0]  part_ff;
   logic [BufAw-1:0] rd_addr_ff;
   logic [7:0]  rd_data;
   logic [7:0]  rec_ff_b [RecBytes];
   logic        rd_pend_ff;
   logic        valid_ff;
   logic [127:0] data_ff;
   logic        last_ff;
   logic [4:0]  shown_c;
   logic [9:0]  end_idx;
   logic [15:0] want;

   dfp_ram #(.Width(8), .Depth(BufLen)) u_buf (
      .clock(clock), .wr_en(cmd.buf_wr), .wr_addr(idx_ff), .wr_data(rx_byte),
      .rd_addr(rd_addr_ff), .rd_data(rd_data)
   );

   // byte index
   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clear) idx_in = '0;
      else if (cmd.idx_load3) idx_in = BufAw'(3);
      else if (cmd.idx_inc) idx_in = idx_ff + 1'b1;
   end

   // running crc
   always_comb begin
      crc_in = crc_ff;
      if (cmd.crc_init) crc_in = crc_byte(16'd0, rx_byte);
      else if (cmd.crc_add) crc_in = crc_byte(crc_ff, rx_byte);
   end

   // shown record count
   always_comb begin
      shown_c = cnt_ff;
      if (shown_c > max_shown) shown_c = max_shown;
      if (shown_c > 5'(MaxTargets)) shown_c = 5'(MaxTargets);
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      crc_ff <= crc_in;
      if (cmd.crc_lo) crc_rx_ff[7:0] <= rx_byte;
      if (cmd.crc_hi) crc_rx_ff[15:8] <= rx_byte;
      if (cmd.chan_store) chan_ff <= rx_byte;
      if (cmd.hdr_store) begin
         cls_ff <= rx_byte[1:0];
      end
      if (cmd.crc_init) cnt_ff <= 5'd0;
      if (cmd.idx_load3) cnt_ff <= rx_byte[4:0];
      if (cmd.rd_start) begin
         shown_ff <= shown_c;
         rec_ff <= '0;
         part_ff <= '0;
         rd_addr_ff <= BufAw'(3);
      end else if (cmd.rec_next) begin
         rec_ff <= rec_ff + 1'b1;
         part_ff <= '0;
      end else if (cmd.rd_step) begin
         rd_addr_ff <= rd_addr_ff + 1'b1;
      end
      if (rd_pend_ff) begin
         rec_ff_b[part_ff] <= rd_data;
         part_ff <= part_ff + 1'b1;
      end
   end

   // read data is registered and arrives in the cycle after the address step
   always_ff @(posedge clock) begin
      if (reset) rd_pend_ff <= 1'b0;
      else rd_pend_ff <= cmd.rd_step;
   end

   // status
   assign end_idx = 10'(cnt_ff) * 10'(RecBytes) + 10'd2;
   assign want = {crc_ff[7:0], crc_ff[15:8]};
   assign stat.data_done  = (10'(idx_ff) >= end_idx);
   assign stat.crc_good   = ({rx_byte, crc_rx_ff[7:0]} == want);
   assign stat.rd_done    = (part_ff == 4'(RecBytes - 1)) && rd_pend_ff;
   assign stat.rec_last   = (rec_ff + 1'b1 == shown_ff);
   assign stat.shown_zero = (shown_c == 5'd0);
   assign stat.out_busy   = valid_ff;

   // output register: fields packed low to high
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (cmd.out_load) valid_ff <= 1'b1;
      else if (out_take) valid_ff <= 1'b0;
      if (cmd.out_load) begin
         logic [4:0] c;
         logic [7:0] ch;
         logic [1:0] cl;
         logic is_tgt;
         logic is_frm;
         logic [127:0] d;
         is_tgt = (cmd.out_kind == EV_TARGET);
         is_frm = is_tgt || cmd.out_kind == EV_CRCERR || cmd.out_kind == EV_OVERFLOW;
         case (cmd.out_cnt_sel)
            2'd0: c = 5'd0;
            2'd1: c = 5'(MaxTargets);
            2'd2: c = cnt_ff;
            2'd3: c = shown_ff;
            default: c = 5'd0;
         endcase
         ch = cmd.out_chan ? chan_ff : 8'd0;
         cl = is_frm ? cls_ff : 2'd0;
         d = '0;
         d[3:0]   = cmd.out_kind;
         d[11:4]  = ch;
         d[13:12] = cl;
         d[18:14] = c;
         if (is_tgt) begin
            d[34:19] = {rec_ff_b[1], rec_ff_b[0]};
            d[50:35] = {rec_ff_b[3], rec_ff_b[2]};
            d[66:51] = {rec_ff_b[5], rec_ff_b[4]};
            d[82:67] = {rec_ff_b[7], rec_ff_b[6]};
            d[90:83] = rec_ff_b[8];
         end
         d[98:91] = cmd.out_use_byte ? rx_byte : 8'd0;
         d[99]    = cmd.out_armed ? armed : 1'b0;
         data_ff <= d;
         last_ff <= !is_tgt || stat.rec_last;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_last  = last_ff;
endmodule

### src/dfp_ctrl.sv
// dfp_ctrl: parser state machine and once/watch flags
// depends on dfp_pkg
module dfp_ctrl import dfp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [7:0]  rx_byte,
   input  logic [7:0]  min_channel,
   input  logic [7:0]  max_channel,
   input  logic [15:0] upgrade_timeout,
   input  stat_type    stat,
   output cmd_type     cmd,
   output logic        armed,
   output state_type   state
);
   state_type state_ff, state_in;
   logic [NumChannels-1:0] marks_ff, marks_in;
   logic        watch_ff, watch_in, md5_ff, md5_in, sdk_ff, sdk_in, armed_ff, armed_in;
   logic [15:0] wcnt_ff, wcnt_in, wcnt_inc;
   logic [7:0]  vcnt_ff, vcnt_in;
   logic [7:0]  chan_ff, chan_in;
   logic        acc, chan_ok;

   assign chan_ok = (rx_byte >= min_channel) && (rx_byte <= max_channel);
   assign wcnt_inc = (wcnt_ff != 16'hFFFF) ? wcnt_ff + 16'd1 : wcnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PS_HUNT;
         marks_ff <= '0;
         watch_ff <= 1'b0;
         md5_ff <= 1'b0;
         sdk_ff <= 1'b0;
         armed_ff <= 1'b0;
         wcnt_ff <= '0;
         vcnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         marks_ff <= marks_in;
         watch_ff <= watch_in;
         md5_ff <= md5_in;
         sdk_ff <= sdk_in;
         armed_ff <= armed_in;
         wcnt_ff <= wcnt_in;
         vcnt_ff <= vcnt_in;
      end
      chan_ff <= chan_in;
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      marks_in = marks_ff;
      watch_in = watch_ff;
      md5_in = md5_ff;
      sdk_in = sdk_ff;
      armed_in = armed_ff;
      wcnt_in = wcnt_ff;
      vcnt_in = vcnt_ff;
      chan_in = chan_ff;
      cmd = '0;
      cmd.out_kind = EV_TARGET;
      in_ready = 1'b0;
      case (state_ff)
         PS_EMIT_RD, PS_EMIT_GATHER, PS_EMIT_OUT: in_ready = 1'b0;
         default: in_ready = !stat.out_busy;
      endcase
      acc = in_valid && in_ready;
      case (state_ff)
         PS_HUNT: if (acc && rx_byte == ByteHdr) begin
            state_in = PS_TYPE;
            if (watch_ff) begin
               wcnt_in = wcnt_inc;
               if (wcnt_inc > upgrade_timeout) begin
                  watch_in = 1'b0;
                  wcnt_in = '0;
                  cmd.out_load = 1'b1;
                  cmd.out_kind = EV_TIMEOUT;
               end
            end
         end
         PS_TYPE: if (acc) begin
            case (rx_byte)
               ByteAa: state_in = PS_AA_CHAN;
               ByteBb: state_in = PS_BB_CHAN;
               ByteCc: state_in = PS_CC_OP;
               ByteDd: begin
                  vcnt_in = '0;
                  state_in = PS_DD_VER;
               end
               default: state_in = PS_HUNT;
            endcase
         end
         PS_AA_CHAN: if (acc) begin
            cmd.chan_store = 1'b1;
            cmd.crc_init = 1'b1;
            chan_in = rx_byte;
            state_in = chan_ok ? PS_AA_CLASS : PS_HUNT;
         end
         PS_AA_CLASS: if (acc) begin
            cmd.hdr_store = 1'b1;
            cmd.crc_add = 1'b1;
            state_in = (rx_byte > 8'd3) ? PS_HUNT : PS_AA_COUNT;
         end
         PS_AA_COUNT: if (acc) begin
            cmd.crc_add = 1'b1;
            cmd.idx_load3 = 1'b1;
            state_in = PS_HUNT;
            cmd.out_chan = 1'b1;
            if (rx_byte == 8'd0) begin
               if (chan_ff < 8'(NumChannels)) begin
                  if (!marks_ff[chan_ff[ChanAw-1:0]]) begin
                     marks_in[chan_ff[ChanAw-1:0]] = 1'b1;
                     cmd.out_load = 1'b1;
                     cmd.out_kind = EV_CLEAR;
                  end
               end else begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = EV_CLEAR;
               end
            end else if (rx_byte > 8'(MaxTargets)) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = EV_OVERFLOW;
               cmd.out_cnt_sel = 2'd1;
            end else begin
               if (chan_ff < 8'(NumChannels)) marks_in[chan_ff[ChanAw-1:0]] = 1'b0;
               state_in = PS_AA_DATA;
            end
         end
         PS_AA_DATA: if (acc) begin
            cmd.buf_wr = 1'b1;
            cmd.crc_add = 1'b1;
            cmd.idx_inc = 1'b1;
            if (stat.data_done) state_in = PS_CRC1;
         end
         PS_CRC1: if (acc) begin
            cmd.crc_lo = 1'b1;
            state_in = PS_CRC2;
         end
         PS_CRC2: if (acc) begin
            cmd.crc_hi = 1'b1;
            cmd.out_chan = 1'b1;
            if (!stat.crc_good) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = EV_CRCERR;
               cmd.out_cnt_sel = 2'd2;
               state_in = PS_HUNT;
            end else if (stat.shown_zero) begin
               state_in = PS_HUNT;
            end else begin
               cmd.rd_start = 1'b1;
               state_in = PS_EMIT_RD;
            end
         end
         PS_EMIT_RD: begin
            cmd.rd_step = 1'b1;
            state_in = PS_EMIT_GATHER;
         end
         PS_EMIT_GATHER: begin
            if (stat.rd_done) state_in = PS_EMIT_OUT;
            else if (!stat.out_busy || 1'b1) cmd.rd_step = 1'b1;
         end
         PS_EMIT_OUT: if (!stat.out_busy) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = EV_TARGET;
            cmd.out_chan = 1'b1;
            cmd.out_cnt_sel = 2'd3;
            if (stat.rec_last) state_in = PS_HUNT;
            else begin
               cmd.rec_next = 1'b1;
               state_in = PS_EMIT_RD;
            end
         end
         PS_BB_CHAN: if (acc) begin
            cmd.chan_store = 1'b1;
            chan_in = rx_byte;
            state_in = chan_ok ? PS_BB_OP : PS_HUNT;
         end
         PS_BB_OP: if (acc) begin
            state_in = PS_HUNT;
            cmd.out_chan = 1'b1;
            if (rx_byte == 8'd0) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = EV_RESEND;
            end else if (rx_byte == 8'd1) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = EV_RANGE;
            end
         end
         PS_CC_OP: if (acc) begin
            state_in = PS_HUNT;
            case (rx_byte)
               OpMd5Req: begin
                  watch_in = 1'b1;
                  md5_in = 1'b0;
                  sdk_in = 1'b0;
                  cmd.out_load = 1'b1;
                  cmd.out_kind = EV_MD5REQ;
               end
               OpMd5Snd: begin
                  wcnt_in = '0;
                  if (!md5_ff) begin
                     md5_in = 1'b1;
                     cmd.out_load = 1'b1;
                     cmd.out_kind = EV_MD5SEND;
                  end
               end
               OpSdk: begin
                  wcnt_in = '0;
                  armed_in = 1'b1;
                  if (!sdk_ff) begin
                     sdk_in = 1'b1;
                     cmd.out_load = 1'b1;
                     cmd.out_kind = EV_SDK;
                  end
               end
               OpFail, OpNone, OpOk: begin
                  watch_in = 1'b0;
                  wcnt_in = '0;
                  cmd.out_load = 1'b1;
                  cmd.out_armed = 1'b1;
                  cmd.out_kind = (rx_byte == OpFail) ? EV_FAIL :
                                 (rx_byte == OpNone) ? EV_NONE : EV_OK;
               end
               default: state_in = PS_CC_OP;
            endcase
         end
         PS_DD_VER: if (acc) begin
            cmd.out_load = 1'b1;
            if (vcnt_ff < 8'(VersionBytes)) begin
               vcnt_in = vcnt_ff + 8'd1;
               cmd.out_kind = EV_VERBYTE;
               cmd.out_use_byte = 1'b1;
            end else begin
               vcnt_in = '0;
               cmd.out_kind = EV_VERDONE;
               state_in = PS_HUNT;
            end
         end
         default: state_in = PS_HUNT;
      endcase
   end

   assign armed = armed_ff;
   assign state = state_ff;
endmodule

### src/detection_frame_parser.sv
// Detection frame parser: takes one received serial byte per req item and parses
// FF-headed frames (AA detections with CRC-16/ARC, BB requests, CC upgrade, DD version),
// giving events on the rsp channel. No byte is taken while the
// output register still holds an item. A good detection frame gives up to
// min(count, max_shown, 20) target items; each is gathered from the frame buffer RAM
// one byte per cycle, then waits out any rsp stall, and no byte is taken meanwhile.
// Depends on dfp_pkg, dfp_ctrl, dfp_dp and dfp_ram.
module detection_frame_parser import dfp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,     // rx_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // event_kind, channel, object_class, target_count, left_x, top_y, right_x,
   // bottom_y, alarm_kind, version_byte, reboot_armed (zero fill to 104 bits)
   output logic [103:0] rsp_tdata,
   output logic         rsp_tlast,     // last
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);
   logic [7:0]  min_ch_ff, max_ch_ff;
   logic [4:0]  max_shown_ff;
   logic [15:0] timeout_ff;
   cmd_type     cmd;
   stat_type    stat;
   logic        armed;
   state_type   state;
   logic [127:0] out_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ch_ff <= 8'd0;
         max_ch_ff <= 8'd3;
         max_shown_ff <= 5'd10;
         timeout_ff <= 16'd5000;
      end else if (csr_wr_en) begin
         case (csr_index)
            CsrMinChan: min_ch_ff <= csr_wdata[7:0];
            CsrMaxChan: max_ch_ff <= csr_wdata[7:0];
            CsrMaxShown: max_shown_ff <= csr_wdata[4:0];
            CsrTimeout: timeout_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   dfp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .rx_byte(req_tdata), .min_channel(min_ch_ff), .max_channel(max_ch_ff),
      .upgrade_timeout(timeout_ff), .stat(stat), .cmd(cmd), .armed(armed), .state(state)
   );

   dfp_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat), .rx_byte(req_tdata),
      .max_shown(max_shown_ff), .armed(armed), .out_take(rsp_tready),
      .out_valid(rsp_tvalid), .out_data(out_data), .out_last(rsp_tlast)
   );

   assign rsp_tdata = out_data[103:0];

`ifndef SYNTH
   // no byte taken during record readout
   a_no_take_emit: assert property (@(posedge clock) disable iff (reset)
      (state == PS_EMIT_RD || state == PS_EMIT_GATHER || state == PS_EMIT_OUT)
      |-> !req_tready) else $error("byte taken during readout");
   // no new item loaded over a pending one
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !cmd.out_load) else $error("result overwritten");
   // target items always carry a nonzero count
   a_tgt_cnt: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[3:0] == EV_TARGET) |-> (rsp_tdata[18:14] != 5'd0))
      else $error("target with zero count");
`endif
endmodule
